>>> src/cfa_pkg.sv
// ----------------------------------------------------------------------------
// cfa_pkg
// Types and constants for the 1/12/19 float adder.
// ----------------------------------------------------------------------------
package cfa_pkg;

   localparam int ExpWidth  = 12;
   localparam int FracWidth = 19;
   localparam int SigWidth  = 32;
   localparam int FracPos   = SigWidth - 1 - FracWidth;
   localparam int LowBits   = SigWidth - FracWidth;
   localparam int ShiftWidth = $clog2(SigWidth);

   typedef struct packed {
      logic                 a_sign;
      logic [ExpWidth-1:0]  a_exp;
      logic [FracWidth-1:0] a_frac;
      logic                 b_sign;
      logic [ExpWidth-1:0]  b_exp;
      logic [FracWidth-1:0] b_frac;
   } req_type;

   typedef struct packed {
      logic                 sum_sign;
      logic [ExpWidth-1:0]  sum_exp;
      logic [FracWidth-1:0] sum_frac;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ALIGN,
      ST_ADD,
      ST_NORM,
      ST_ROUND,
      ST_DONE
   } state_type;

endpackage

>>> src/custom_float32_adder.sv
// ----------------------------------------------------------------------------
// custom_float32_adder
// Float adder, sign/12/19 format, bias 2047, truncating alignment.
//
//   channel | direction | ports
//   req     | in        | req_valid, req_stall, req_word
//   rsp     | out       | rsp_valid, rsp_stall, rsp_word
//
// from accept to result valid: like signs pass align, add and round; unlike
// signs also pass the normalise loop; exact cancellation ends after add, a
// far operand after align and a zero operand goes straight to done.
// the normalise loop shifts one bit a cycle through a single shifter.
// reset clears the sequencer and the output valid.
// a stalled result holds the block; the next word is taken the cycle after
// the result leaves.
// ----------------------------------------------------------------------------
module custom_float32_adder (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  cfa_pkg::req_type  req_word,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output cfa_pkg::rsp_type  rsp_word
);

   cfa_pkg::state_type state_ff, state_in;
   logic                              sign_ff, sign_in;
   logic [cfa_pkg::ExpWidth-1:0]      exp_ff, exp_in;
   logic [cfa_pkg::ExpWidth-1:0]      eb_ff, eb_in;
   logic [cfa_pkg::SigWidth-1:0]      ma_ff, ma_in;
   logic [cfa_pkg::SigWidth-1:0]      mb_ff, mb_in;
   logic                              unlike_ff, unlike_in;
   logic                              bsel_ff, bsel_in;
   logic                              rvalid_ff, rvalid_in;
   cfa_pkg::rsp_type                  rsp_ff, rsp_in;

   // combinational helpers
   logic [cfa_pkg::ExpWidth-1:0]      diff;
   logic [cfa_pkg::SigWidth:0]        wide;
   logic [cfa_pkg::SigWidth-1:0]      sum_lo;
   logic                              g_bit, b_bit, r_bit, s_bit;
   logic [cfa_pkg::SigWidth-cfa_pkg::LowBits:0] rnd;

   assign req_stall = (state_ff != cfa_pkg::ST_IDLE) || rvalid_ff;
   assign rsp_valid = rvalid_ff;
   assign rsp_word  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= cfa_pkg::ST_IDLE;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rvalid_ff <= rvalid_in;
      end
      sign_ff   <= sign_in;
      exp_ff    <= exp_in;
      eb_ff     <= eb_in;
      ma_ff     <= ma_in;
      mb_ff     <= mb_in;
      unlike_ff <= unlike_in;
      bsel_ff   <= bsel_in;
      rsp_ff    <= rsp_in;
   end

   // sequencer and datapath
   always_comb begin
      state_in  = state_ff;
      sign_in   = sign_ff;
      exp_in    = exp_ff;
      eb_in     = eb_ff;
      ma_in     = ma_ff;
      mb_in     = mb_ff;
      unlike_in = unlike_ff;
      bsel_in   = bsel_ff;
      rvalid_in = rvalid_ff && rsp_stall;
      rsp_in    = rsp_ff;
      diff      = exp_ff - eb_ff;
      wide      = {1'b0, ma_ff} + {1'b0, mb_ff};
      sum_lo    = wide[cfa_pkg::SigWidth-1:0];
      b_bit     = ma_ff[cfa_pkg::LowBits];
      g_bit     = ma_ff[cfa_pkg::LowBits-1];
      r_bit     = ma_ff[cfa_pkg::LowBits-2];
      s_bit     = |ma_ff[cfa_pkg::LowBits-3:0];
      rnd       = {1'b0, ma_ff[cfa_pkg::SigWidth-1:cfa_pkg::LowBits]} + 1'b1;
      case (state_ff)
         cfa_pkg::ST_IDLE: begin
            if (req_valid && !req_stall) begin
               unlike_in = req_word.a_sign ^ req_word.b_sign;
               if (req_word.a_exp == '0 && req_word.a_frac == '0) begin
                  rsp_in    = '{req_word.b_sign, req_word.b_exp, req_word.b_frac};
                  state_in  = cfa_pkg::ST_DONE;
               end else if (req_word.b_exp == '0 && req_word.b_frac == '0) begin
                  rsp_in    = '{req_word.a_sign, req_word.a_exp, req_word.a_frac};
                  state_in  = cfa_pkg::ST_DONE;
               end else if (req_word.a_exp < req_word.b_exp) begin
                  // swap so larger exponent leads; bsel records no-swap xor the sign of b
                  sign_in  = req_word.b_sign;
                  exp_in   = req_word.b_exp;
                  eb_in    = req_word.a_exp;
                  ma_in    = {1'b1, req_word.b_frac, {cfa_pkg::FracPos{1'b0}}};
                  mb_in    = {1'b1, req_word.a_frac, {cfa_pkg::FracPos{1'b0}}};
                  bsel_in  = 1'b0 ^ req_word.b_sign;
                  rsp_in   = '{req_word.b_sign, req_word.b_exp, req_word.b_frac};
                  state_in = cfa_pkg::ST_ALIGN;
               end else begin
                  sign_in  = req_word.a_sign;
                  exp_in   = req_word.a_exp;
                  eb_in    = req_word.b_exp;
                  ma_in    = {1'b1, req_word.a_frac, {cfa_pkg::FracPos{1'b0}}};
                  mb_in    = {1'b1, req_word.b_frac, {cfa_pkg::FracPos{1'b0}}};
                  bsel_in  = 1'b1 ^ req_word.b_sign;
                  rsp_in   = '{req_word.a_sign, req_word.a_exp, req_word.a_frac};
                  state_in = cfa_pkg::ST_ALIGN;
               end
            end
         end
         cfa_pkg::ST_ALIGN: begin
            // far operand returns the leader unchanged
            if (diff[cfa_pkg::ExpWidth-1:cfa_pkg::ShiftWidth] != '0) begin
               state_in = cfa_pkg::ST_DONE;
            end else begin
               mb_in = mb_ff >> diff[cfa_pkg::ShiftWidth-1:0];
               if (unlike_ff) begin
                  mb_in = '0 - (mb_ff >> diff[cfa_pkg::ShiftWidth-1:0]);
               end
               state_in = cfa_pkg::ST_ADD;
            end
         end
         cfa_pkg::ST_ADD: begin
            if (!unlike_ff) begin
               if (wide[cfa_pkg::SigWidth]) begin
                  ma_in  = sum_lo;
                  exp_in = exp_ff + 1'b1;
               end else begin
                  ma_in  = {sum_lo[cfa_pkg::SigWidth-2:0], 1'b0};
               end
               state_in = cfa_pkg::ST_ROUND;
            end else begin
               sign_in = (~wide[cfa_pkg::SigWidth]) ^ bsel_ff;
               ma_in   = wide[cfa_pkg::SigWidth] ? sum_lo : ('0 - sum_lo);
               if (sum_lo == '0) begin
                  rsp_in   = '0;
                  state_in = cfa_pkg::ST_DONE;
               end else begin
                  state_in = cfa_pkg::ST_NORM;
               end
            end
         end
         cfa_pkg::ST_NORM: begin
            // one bit a cycle until the leading one drops out at the top
            ma_in = {ma_ff[cfa_pkg::SigWidth-2:0], 1'b0};
            if (ma_ff[cfa_pkg::SigWidth-1]) begin
               state_in = cfa_pkg::ST_ROUND;
            end else begin
               exp_in = exp_ff - 1'b1;
            end
         end
         cfa_pkg::ST_ROUND: begin
            rsp_in = '{sign_ff, exp_ff, ma_ff[cfa_pkg::SigWidth-1:cfa_pkg::LowBits]};
            if (g_bit && (b_bit || r_bit || s_bit)) begin
               rsp_in.sum_frac = rnd[cfa_pkg::FracWidth-1:0];
               if (rnd[cfa_pkg::FracWidth]) begin
                  rsp_in.sum_exp = exp_ff + 1'b1;
               end
            end
            state_in = cfa_pkg::ST_DONE;
         end
         cfa_pkg::ST_DONE: begin
            if (!rvalid_ff) begin
               rvalid_in = 1'b1;
               state_in  = cfa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cfa_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

>>> tb/custom_float32_adder_tb.sv
// ----------------------------------------------------------------------------
// custom_float32_adder_tb
// Self-checking bench for the 1/12/19 float adder: directed operand words,
// then random ones, each sum checked against a given sum or a behavioural
// adder model, with random idling on both channels.
// ----------------------------------------------------------------------------
module custom_float32_adder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NumRandom = 800;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   cfa_pkg::req_type req_word = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   cfa_pkg::rsp_type rsp_word;

   cfa_pkg::rsp_type sum_queue[$];
   int      error_count = 0;
   bit      quiet_phase = 1'b0;
   bit      stim_done = 1'b0;

   custom_float32_adder dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word)
   );

   always #1 clock = ~clock;

   // behavioural model of the adder
   function automatic cfa_pkg::rsp_type float_sum(cfa_pkg::req_type w);
      cfa_pkg::rsp_type r;
      logic        as, bs, unlike, swapped, carry, sgn;
      logic [11:0] ae, be, ex;
      logic [18:0] af, bf;
      logic [31:0] ma, mb, sm, diff;
      logic [32:0] wide;
      as = w.a_sign; ae = w.a_exp; af = w.a_frac;
      bs = w.b_sign; be = w.b_exp; bf = w.b_frac;
      swapped = 1'b0;
      if (ae == 0 && af == 0) return '{bs, be, bf};
      if (be == 0 && bf == 0) return '{as, ae, af};
      unlike = as ^ bs;
      if (ae < be) begin
         swapped = 1'b1;
         {as, ae, af, bs, be, bf} = {bs, be, bf, as, ae, af};
      end
      diff = 32'(ae) - 32'(be);
      if (diff >= 32) return '{as, ae, af};
      ma = {1'b1, af, 12'b0};
      mb = {1'b1, bf, 12'b0} >> diff;
      ex = ae;
      if (unlike) mb = -mb;
      wide = {1'b0, ma} + {1'b0, mb};
      sm = wide[31:0];
      carry = wide[32];
      if (unlike && !carry) sm = -sm;
      if (!unlike) begin
         if (!carry) sm = sm << 1;
         else ex = ex + 12'd1;
      end else begin
         if (sm == 0) return '0;
         while (!sm[31]) begin
            sm = sm << 1;
            ex = ex - 12'd1;
         end
         sm = sm << 1;
      end
      // round up on guard with lsb, round or sticky
      if (sm[12] && (sm[13] || sm[11] || sm[10:0] != 0)) begin
         sm = sm + 32'h2000;
         if (sm[31:13] == 0) ex = ex + 12'd1;
      end
      if (!unlike) sgn = as;
      else sgn = (~carry) ^ (~swapped) ^ w.b_sign;
      r.sum_sign = sgn; r.sum_exp = ex; r.sum_frac = sm[31:13];
      return r;
   endfunction

   function automatic cfa_pkg::req_type random_word();
      cfa_pkg::req_type w;
      int      k;
      w = cfa_pkg::req_type'({$urandom, $urandom});
      k = $urandom_range(0, 9);
      // mostly close exponents so the adder does real work
      if (k < 6) w.b_exp = w.a_exp + 12'($urandom_range(0, 40)) - 12'd20;
      if (k == 6) begin
         w.b_exp = w.a_exp; w.b_frac = w.a_frac; w.b_sign = ~w.a_sign;
      end
      if (k == 7) begin
         w.b_exp = w.a_exp; w.b_sign = ~w.a_sign;
         w.b_frac = w.a_frac ^ 19'(1 << $urandom_range(0, 18));
      end
      if (k == 8 && $urandom_range(0, 1)) {w.a_exp, w.a_frac} = '0;
      if (k == 8 && $urandom_range(0, 1)) {w.b_exp, w.b_frac} = '0;
      return w;
   endfunction

   typedef struct {
      cfa_pkg::req_type op;
      bit               typed;
      cfa_pkg::rsp_type sum;
   } vector_type;

   vector_type directed[] = '{
      '{'{1'b0, 12'd0, 19'd0, 1'b1, 12'd4095, 19'h7ffff}, 1, '{1'b1, 12'd4095, 19'h7ffff}},
      '{'{1'b1, 12'd4095, 19'h7ffff, 1'b0, 12'd0, 19'd0}, 1, '{1'b1, 12'd4095, 19'h7ffff}},
      '{'{1'b0, 12'd0, 19'd0, 1'b0, 12'd0, 19'd0}, 1, '{1'b0, 12'd0, 19'd0}},
      '{'{1'b0, 12'd2047, 19'd5, 1'b1, 12'd2047, 19'd5}, 1, '{1'b0, 12'd0, 19'd0}},
      '{'{1'b1, 12'd4095, 19'h12345, 1'b0, 12'd4095, 19'h12345}, 1, '{1'b0, 12'd0, 19'd0}},
      '{'{1'b0, 12'd2100, 19'h1234, 1'b1, 12'd2068, 19'h7ffff}, 1, '{1'b0, 12'd2100, 19'h1234}},
      '{'{1'b1, 12'd100, 19'h7ffff, 1'b0, 12'd3000, 19'h00001}, 1, '{1'b0, 12'd3000, 19'h00001}},
      '{'{1'b0, 12'd2047, 19'd0, 1'b0, 12'd2047, 19'd0}, 0, '0},
      '{'{1'b0, 12'd4095, 19'h7ffff, 1'b0, 12'd4095, 19'h7ffff}, 0, '0},
      '{'{1'b0, 12'd0, 19'd1, 1'b1, 12'd0, 19'd0}, 0, '0},
      '{'{1'b0, 12'd0, 19'd3, 1'b1, 12'd1, 19'd0}, 0, '0},
      '{'{1'b0, 12'd2047, 19'h7ffff, 1'b0, 12'd2016, 19'h7ffff}, 0, '0},
      '{'{1'b0, 12'd2047, 19'h7ffff, 1'b0, 12'd2035, 19'h7ffff}, 0, '0},
      '{'{1'b0, 12'd2047, 19'd0, 1'b1, 12'd2047, 19'd1}, 0, '0},
      '{'{1'b1, 12'd2047, 19'h40000, 1'b0, 12'd2046, 19'h7ffff}, 0, '0},
      '{'{1'b0, 12'd2000, 19'h2aaaa, 1'b1, 12'd2001, 19'h55555}, 0, '0},
      '{'{1'b1, 12'd10, 19'h7fffe, 1'b1, 12'd11, 19'h00001}, 0, '0}
   };

   // drive one operand word, idling at random beforehand
   task automatic send_word(cfa_pkg::req_type w, bit typed, cfa_pkg::rsp_type sum);
      while (!quiet_phase && $urandom_range(0, 99) < 16) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      sum_queue = {sum_queue, (typed ? sum : float_sum(w))};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // stimulus
   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (directed[i]) send_word(directed[i].op, directed[i].typed, directed[i].sum);
      for (int i = 0; i < NumRandom; i++) begin
         quiet_phase = (i >= 300 && i < 400);
         send_word(random_word(), 1'b0, '0);
      end
      req_valid <= 1'b0;
      stim_done = 1'b1;
   end

   // result side stall
   always @(negedge clock)
      rsp_stall <= !quiet_phase && ($urandom_range(0, 99) < 16);

   // check each sum word against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (sum_queue.size() == 0) begin
            $display("%0t: unexpected sum word, expected none, actual %h", $time, rsp_word);
            error_count++;
         end else begin
            cfa_pkg::rsp_type want;
            want = sum_queue.pop_front();
            if (want.sum_sign !== rsp_word.sum_sign || want.sum_exp !== rsp_word.sum_exp ||
                want.sum_frac !== rsp_word.sum_frac) begin
               $display("%0t: sum mismatch, expected %h/%h/%h, actual %h/%h/%h", $time,
                        want.sum_sign, want.sum_exp, want.sum_frac,
                        rsp_word.sum_sign, rsp_word.sum_exp, rsp_word.sum_frac);
               error_count++;
            end
         end
      end
   end

   // end of run
   initial begin
      wait (stim_done);
      while (sum_queue.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // watchdog
   initial begin
      #1ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

>>> files.f
src/cfa_pkg.sv
src/custom_float32_adder.sv
tb/custom_float32_adder_tb.sv
